[hw/rtl/sac_pkg.sv]
// Shared types, operation codes and status codes of the stack calculator.
`default_nettype none

package sac_pkg;

    localparam int DATA_W          = 32;
    localparam int FUNC_W          = 3;
    localparam int STATUS_W        = 2;
    localparam int DEPTH_W         = 5;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd3;

    typedef struct packed {
        logic        [FUNC_W-1:0] func;
        logic signed [DATA_W-1:0] value;
    } sac_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   result;
        logic        [STATUS_W-1:0] status;
        logic        [DEPTH_W-1:0]  depth;
    } sac_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                set_status; // clear result and load the status code
        logic [STATUS_W-1:0] status;
        logic                push;       // write the input value on top, count up
        logic                pop;        // count down
        logic                rd_top;     // read the top entry
        logic                rd_second;  // read the entry below the top
        logic                take_rd;    // result takes the read data
        logic                latch_a;    // operand A takes the read data
        logic                alu;        // result takes A op B
        logic [FUNC_W-1:0]   op;
        logic                div_start;
        logic                div_take;   // result takes the quotient
        logic                write_back; // replace B with the result, count down
        logic                load_out;   // load the output register
    } sac_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sp_zero;
        logic sp_lt2;
        logic sp_full;
        logic b_zero;
        logic div_done;
    } sac_sts_t;

endpackage

`default_nettype wire

[hw/rtl/stack_calculator_alu.sv]
// Top level of the 32-bit signed stack calculator.
//
// The input channel (s_valid, s_ready, s_data) carries one transaction per
// operation: an operation code and a value that only push uses. The result
// channel (m_valid, m_ready, m_data) returns exactly one transaction per
// operation with the result, a status code and the stack depth afterwards.
// Errors (underflow, overflow, divide by zero) are reported in status and
// leave the stack untouched.
// One operation is worked on at a time. Push, errors and unused codes go
// straight to the output state; pop passes through a capture state; add,
// subtract and multiply read both operands, execute and write back, and a
// divide by zero ends after the operand reads. Divide runs through a
// one-bit-per-cycle divider before the write back. Input ready returns in
// the cycle the result appears.
// The stack lives in a single-port-read memory, so the two operands of an
// arithmetic operation are fetched one after the other, the top entry first.
// A result waiting in the output register does not block the next
// operation; only a second finished result waits until the receiver takes
// the first. Reset empties the stack and drops any pending transaction.
`default_nettype none

module stack_calculator_alu #(
    parameter int STACK_DEPTH = sac_pkg::STACK_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire sac_pkg::sac_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output sac_pkg::sac_out_t     m_data
);
    import sac_pkg::*;

    // Command and status groups between the controller and the datapath.
    sac_cmd_t cmd;
    sac_sts_t sts;

    // The controller decides the sequence of each operation from its code and
    // from the stack status; it also owns the output valid flag.
    sac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_data.func),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // The datapath holds the stack, the operand and result registers, the
    // divider and the output payload register.
    sac_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

[hw/rtl/sac_div.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module sac_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [sac_pkg::DATA_W-1:0] dividend,
    input  wire logic [sac_pkg::DATA_W-1:0] divisor,
    output logic                           done,
    output logic [sac_pkg::DATA_W-1:0]      quotient
);
    import sac_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              fix_reg, fix_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W+1:0] diff;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign diff = {1'b0, rem_reg, quo_reg[DATA_W-1]} - {2'b00, dvs_reg};

    always_comb begin
        busy_next  = busy_reg;
        fix_next   = 1'b0;
        done_next  = 1'b0;
        count_next = count_reg;
        neg_next   = neg_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            neg_next   = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rem_next   = '0;
            quo_next   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            dvs_next   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
        end else if (busy_reg) begin
            if (!diff[DATA_W+1]) begin
                rem_next = diff[DATA_W-1:0];
            end else begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
            end
            quo_next   = {quo_reg[DATA_W-2:0], ~diff[DATA_W+1]};
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end else if (fix_reg) begin
            quo_next  = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            fix_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            fix_reg   <= fix_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[hw/rtl/sac_ctrl.sv]
// Controller state machine of the stack calculator: sequencing and output valid.
`default_nettype none

module sac_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    input  wire logic [sac_pkg::FUNC_W-1:0] s_func,
    output logic                           s_ready,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output sac_pkg::sac_cmd_t              cmd,
    input  wire sac_pkg::sac_sts_t         sts
);
    import sac_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_POPCAP = 3'd1;
    localparam logic [2:0] S_RDB    = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_WB     = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic              out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.op         = func_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OK;
                    func_next      = s_func;
                    state_next     = S_OUT;
                    unique case (s_func) inside
                        FUNC_PUSH: begin
                            if (sts.sp_full) begin
                                cmd.status = ST_OVER;
                            end else begin
                                cmd.push = 1'b1;
                            end
                        end
                        FUNC_POP: begin
                            if (sts.sp_zero) begin
                                cmd.status = ST_UNDER;
                            end else begin
                                cmd.rd_top = 1'b1;
                                cmd.pop    = 1'b1;
                                state_next = S_POPCAP;
                            end
                        end
                        FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
                            if (sts.sp_lt2) begin
                                cmd.status = ST_UNDER;
                            end else begin
                                cmd.rd_top = 1'b1;
                                state_next = S_RDB;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POPCAP: begin
                cmd.take_rd = 1'b1;
                state_next  = S_OUT;
            end
            S_RDB: begin
                cmd.rd_second = 1'b1;
                cmd.latch_a   = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC: begin
                if (func_reg == FUNC_DIV) begin
                    if (sts.b_zero) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_DIV0;
                        state_next     = S_OUT;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end else begin
                    cmd.alu    = 1'b1;
                    state_next = S_WB;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    cmd.div_take = 1'b1;
                    state_next   = S_WB;
                end
            end
            S_WB: begin
                cmd.write_back = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg <= func_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

    // The output register is only reloaded when its transaction is gone or leaving.
    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("output register overwritten while full");

    // The divider only finishes while the controller waits for it.
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    // An accepted operation code is kept for the rest of the item.
    a_func_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (func_reg == $past(s_func)))
        else $error("operation code not captured on accept");

endmodule

`default_nettype wire

[hw/rtl/sac_dp.sv]
// Datapath of the stack calculator: stack memory, pointer, ALU, divider and output register.
`default_nettype none

module sac_dp #(
    parameter int STACK_DEPTH = sac_pkg::STACK_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sac_pkg::sac_in_t  s_data,
    input  wire sac_pkg::sac_cmd_t cmd,
    output sac_pkg::sac_sts_t      sts,
    output sac_pkg::sac_out_t      m_data
);
    import sac_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
    logic [PW-1:0]       sp_reg, sp_next;
    logic [DATA_W-1:0]   rdata_reg;
    logic [DATA_W-1:0]   a_reg;
    logic [DATA_W-1:0]   result_reg, result_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    sac_out_t            out_reg;
    logic [PW-1:0]       sp_m1, sp_m2;
    logic [AW-1:0]       raddr;
    logic                rd_en;
    logic                wr_en;
    logic [AW-1:0]       waddr;
    logic [DATA_W-1:0]   wdata;
    logic [DATA_W-1:0]   alu_out;
    logic                div_done;
    logic [DATA_W-1:0]   div_quo;

    assign sp_m1 = sp_reg - 1'b1;
    assign sp_m2 = sp_reg - PW'(2);

    assign rd_en = cmd.rd_top || cmd.rd_second;
    assign raddr = cmd.rd_second ? sp_m2[AW-1:0] : sp_m1[AW-1:0];
    assign wr_en = cmd.push || cmd.write_back;
    assign waddr = cmd.push ? sp_reg[AW-1:0] : sp_m2[AW-1:0];
    assign wdata = cmd.push ? s_data.value : result_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= stack_mem[raddr];
        end
    end

    // A is the top entry and B the one below it; B arrives as the read data.
    always_comb begin
        case (cmd.op)
            FUNC_ADD: alu_out = a_reg + rdata_reg;
            FUNC_SUB: alu_out = a_reg - rdata_reg;
            FUNC_MUL: alu_out = a_reg * rdata_reg;
            default:  alu_out = '0;
        endcase
    end

    sac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (a_reg),
        .divisor  (rdata_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        sp_next     = sp_reg;
        result_next = result_reg;
        status_next = status_reg;
        if (cmd.set_status) begin
            result_next = '0;
            status_next = cmd.status;
        end
        if (cmd.push) begin
            sp_next = sp_reg + 1'b1;
        end else if (cmd.pop || cmd.write_back) begin
            sp_next = sp_m1;
        end
        if (cmd.take_rd) begin
            result_next = rdata_reg;
        end else if (cmd.alu) begin
            result_next = alu_out;
        end else if (cmd.div_take) begin
            result_next = div_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
        status_reg <= status_next;
        if (cmd.latch_a) begin
            a_reg <= rdata_reg;
        end
        if (cmd.load_out) begin
            out_reg.result <= result_reg;
            out_reg.status <= status_reg;
            out_reg.depth  <= DEPTH_W'(sp_reg);
        end
    end

    assign sts.sp_zero  = (sp_reg == '0);
    assign sts.sp_lt2   = (sp_reg < PW'(2));
    assign sts.sp_full  = (sp_reg == PW'(STACK_DEPTH));
    assign sts.b_zero   = (rdata_reg == '0);
    assign sts.div_done = div_done;
    assign m_data       = out_reg;

    a_sp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= PW'(STACK_DEPTH))
        else $error("stack pointer beyond the stack depth");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (sp_reg < PW'(STACK_DEPTH)))
        else $error("push issued on a full stack");

    a_wb_two_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_back |-> (sp_reg >= PW'(2)))
        else $error("write back with fewer than two entries");

endmodule

`default_nettype wire
